// ===== design/assert_macros.svh =====
// Assertion macros shared by the limiter checker.
// Include by bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLIM_ASSERT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLIM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("limiter check failed");

`endif

// ===== design/clim_pkg.sv =====
// Package for the per-class limiter: sizes, mode and register codes, table entry type.
// No dependencies; imported by every limiter module.
`default_nettype none
package clim_pkg;

	localparam int CLASS_COUNT = 64;
	localparam int LIMIT_WIDTH = 16;
	localparam int TOTAL_WIDTH = 32;
	localparam int CLASS_W     = $clog2(CLASS_COUNT);
	localparam int MODE_W      = 3;
	localparam int CLASS_IN_W  = 6;
	localparam int STAMP_W     = 32;
	localparam int REG_IDX_W   = 2;

	typedef logic [CLASS_W-1:0]     cls_t;
	typedef logic [LIMIT_WIDTH-1:0] lim_t;
	typedef logic [TOTAL_WIDTH-1:0] tot_t;
	typedef logic [STAMP_W-1:0]     stamp_t;
	typedef logic [MODE_W-1:0]      mode_t;

	localparam mode_t MODE_REQUEST   = 3'd0;
	localparam mode_t MODE_FINISH    = 3'd1;
	localparam mode_t MODE_STATS     = 3'd2;
	localparam mode_t MODE_CONFIGURE = 3'd3;
	localparam mode_t MODE_TICK      = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_EN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_MIF = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_MPS = 2'd2;

	// One class entry, read and written whole.
	typedef struct packed {
		logic   configured;
		logic   enabled;
		lim_t   max_in_flight;
		lim_t   max_per_second;
		lim_t   in_flight;
		lim_t   window_count;
		stamp_t window_stamp;
		tot_t   accepted;
		tot_t   dropped;
	} entry_t;

	// Default limits from the configuration registers.
	typedef struct packed {
		logic enabled;
		lim_t max_in_flight;
		lim_t max_per_second;
	} defaults_t;

endpackage
`default_nettype wire

// ===== design/clim_table.sv =====
// Class table: entry memory with registered read, per-entry valid bits and
// write-to-read forwarding. Depends on clim_pkg.
`default_nettype none
module clim_table import clim_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   rd_en,
	input  wire cls_t   rd_addr,
	input  wire logic   wr_en,
	input  wire cls_t   wr_addr,
	input  wire entry_t wr_data,
	output entry_t      rd_data
);

	entry_t                 mem [CLASS_COUNT];
	logic [CLASS_COUNT-1:0] valid_q;
	entry_t                 rd_q;
	logic                   rd_valid_q;
	entry_t                 fwd_q;
	logic                   fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		fwd_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				// the memory returns old data when the same entry is written this edge
				fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// a never-written entry reads as all zero
	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_q;
		end else if (rd_valid_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule
`default_nettype wire

// ===== design/clim_update.sv =====
// Per-beat entry update: admission decision, window restart, counter saturation.
// Pure combinational logic. Depends on clim_pkg.
`default_nettype none
module clim_update import clim_pkg::*; (
	input  wire logic      valid,
	input  wire mode_t     mode,
	input  wire logic      set_enabled,
	input  wire lim_t      set_max_in_flight,
	input  wire lim_t      set_max_per_second,
	input  wire defaults_t defaults,
	input  wire stamp_t    second_now,
	input  wire entry_t    cur,
	output entry_t         nxt,
	output logic           wr_en,
	output logic           admitted
);

	localparam lim_t LIM_MAX = '1;
	localparam tot_t TOT_MAX = '1;

	logic                 en;
	lim_t                 maxc;
	lim_t                 maxq;
	logic                 drop;
	lim_t                 wc;
	logic [LIMIT_WIDTH:0] q;

	always_comb begin
		if (cur.configured) begin
			en   = cur.enabled;
			maxc = cur.max_in_flight;
			maxq = cur.max_per_second;
		end else begin
			en   = defaults.enabled;
			maxc = defaults.max_in_flight;
			maxq = defaults.max_per_second;
		end

		nxt      = cur;
		drop     = 1'b0;
		admitted = 1'b0;
		wc       = cur.window_count;
		q        = '0;
		wr_en    = 1'b0;

		case (mode)
			MODE_REQUEST: begin
				wr_en = valid;
				if (en && (maxc != '0)) begin
					if (cur.in_flight >= maxc) begin
						drop = 1'b1;
					end else begin
						nxt.in_flight = cur.in_flight + 1'b1;
					end
				end
				if (en && !drop && (maxq != '0)) begin
					// restart a stale window
					if (cur.window_stamp != second_now) begin
						nxt.window_stamp = second_now;
						wc = '0;
					end
					q = {1'b0, wc} + 1'b1;
					nxt.window_count = q[LIMIT_WIDTH] ? LIM_MAX : q[LIMIT_WIDTH-1:0];
					if (q > {1'b0, maxq}) begin
						drop = 1'b1;
						// give back the slot taken above
						if ((maxc != '0) && (nxt.in_flight != '0)) begin
							nxt.in_flight = nxt.in_flight - 1'b1;
						end
					end
				end
				if (drop) begin
					nxt.dropped = (cur.dropped == TOT_MAX) ? TOT_MAX : cur.dropped + 1'b1;
				end else begin
					nxt.accepted = (cur.accepted == TOT_MAX) ? TOT_MAX : cur.accepted + 1'b1;
					admitted = 1'b1;
				end
			end
			MODE_FINISH: begin
				wr_en = valid;
				if (en && (maxc != '0) && (cur.in_flight != '0)) begin
					nxt.in_flight = cur.in_flight - 1'b1;
				end
			end
			MODE_CONFIGURE: begin
				wr_en = valid;
				nxt.configured     = 1'b1;
				nxt.enabled        = set_enabled;
				nxt.max_in_flight  = set_max_in_flight;
				nxt.max_per_second = set_max_per_second;
			end
			default: begin
				// stats query, tick and unused codes leave the entry alone
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/per_class_rate_and_concurrency_limiter_core.sv =====
// Top level of the per-class limiter: input and result registers, defaults,
// second counter. Depends on clim_pkg, clim_table and clim_update.
//
//   channel   handshake                 payload
//   command   start / busy              mode, msg_class, set_enabled, set_max_*
//   result    done (one-cycle strobe)   admitted, accepted_total, dropped_total,
//                                       in_flight_now, window_count_now
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One command beat is taken every cycle; busy stays low.
// Each result passes through the registered table read, then through the update
// and the result register.
// A back-to-back beat to the same class is served from the forwarded write.
// Reset clears the valid bits of all 64 entries at once; no clearing pass.
// The receiver cannot stall, so nothing ever holds the pipeline.
`default_nettype none
module per_class_rate_and_concurrency_limiter_core import clim_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [CLASS_IN_W-1:0] msg_class,
	input  wire logic                  set_enabled,
	input  wire logic [LIMIT_WIDTH-1:0] set_max_in_flight,
	input  wire logic [LIMIT_WIDTH-1:0] set_max_per_second,
	output logic                       done,
	output logic                       admitted,
	output logic [TOTAL_WIDTH-1:0]     accepted_total,
	output logic [TOTAL_WIDTH-1:0]     dropped_total,
	output logic [LIMIT_WIDTH-1:0]     in_flight_now,
	output logic [LIMIT_WIDTH-1:0]     window_count_now,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [LIMIT_WIDTH-1:0] cfg_data
);

	logic      accept;
	cls_t      cls_in;
	logic      valid_s1;
	mode_t     mode_s1;
	cls_t      cls_s1;
	logic      set_en_s1;
	lim_t      set_mif_s1;
	lim_t      set_mps_s1;
	defaults_t defaults_q;
	stamp_t    second_q;
	entry_t    cur_entry;
	entry_t    nxt_entry;
	logic      wr_en;
	logic      adm;
	logic      done_s2;
	logic      admitted_s2;
	tot_t      accepted_s2;
	tot_t      dropped_s2;
	lim_t      in_flight_s2;
	lim_t      window_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cls_in    = CLASS_W'(msg_class);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= mode;
			cls_s1     <= cls_in;
			set_en_s1  <= set_enabled;
			set_mif_s1 <= set_max_in_flight;
			set_mps_s1 <= set_max_per_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defaults_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEFAULT_EN:  defaults_q.enabled        <= cfg_data[0];
				REG_DEFAULT_MIF: defaults_q.max_in_flight  <= cfg_data;
				REG_DEFAULT_MPS: defaults_q.max_per_second <= cfg_data;
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= '0;
		end else if (valid_s1 && (mode_s1 == MODE_TICK)) begin
			second_q <= second_q + 1'b1;
		end
	end

	clim_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (cls_in),
		.wr_en   (wr_en),
		.wr_addr (cls_s1),
		.wr_data (nxt_entry),
		.rd_data (cur_entry)
	);

	clim_update u_update (
		.valid              (valid_s1),
		.mode               (mode_s1),
		.set_enabled        (set_en_s1),
		.set_max_in_flight  (set_mif_s1),
		.set_max_per_second (set_mps_s1),
		.defaults           (defaults_q),
		.second_now         (second_q),
		.cur                (cur_entry),
		.nxt                (nxt_entry),
		.wr_en              (wr_en),
		.admitted           (adm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2     <= 1'b0;
			admitted_s2 <= 1'b0;
		end else begin
			done_s2     <= valid_s1;
			admitted_s2 <= valid_s1 && adm;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			accepted_s2  <= nxt_entry.accepted;
			dropped_s2   <= nxt_entry.dropped;
			in_flight_s2 <= nxt_entry.in_flight;
			window_s2    <= nxt_entry.window_count;
		end
	end

	assign done             = done_s2;
	assign admitted         = admitted_s2;
	assign accepted_total   = accepted_s2;
	assign dropped_total    = dropped_s2;
	assign in_flight_now    = in_flight_s2;
	assign window_count_now = window_s2;

endmodule
`default_nettype wire

// ===== design/clim_check.sv =====
// Port-level checker for the per-class limiter, bound to the top level.
// Depends on clim_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module clim_check import clim_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [MODE_W-1:0] mode,
	input wire logic              done,
	input wire logic              admitted
);

	// every command beat is followed by a result
	`CLIM_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, ##1 done)
	// no result without an earlier command beat
	`CLIM_ASSERT(a_no_spurious, clk, arst_n, done, $past(start && !busy, 2))
	// admission is only reported on a result beat
	`CLIM_ASSERT(a_adm_on_done, clk, arst_n, admitted, done)
	// only requests can be admitted
	`CLIM_ASSERT(a_adm_request, clk, arst_n, done && ($past(mode, 2) != MODE_REQUEST), !admitted)

endmodule

bind per_class_rate_and_concurrency_limiter_core clim_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.mode     (mode),
	.done     (done),
	.admitted (admitted)
);
`default_nettype wire
